### sv/tms_pkg.sv
// Shared types and constants for the temporal median select block.
package tms_pkg;

  localparam int SAMPLE_W      = 16;
  localparam int SAMPLE_FIELDS = 5;
  localparam int COUNT_W       = 3;
  localparam int MIN_FRAMES    = 3;

  typedef logic [SAMPLE_W-1:0] sample_t;
  typedef logic [COUNT_W-1:0]  count_t;

  // what one lane reports for its own sample
  typedef struct packed {
    logic    used;
    count_t  rank;
    sample_t value;
  } lane_res_t;

endpackage

### sv/tms_rank_lane.sv
// One rank lane: counts how many samples in use sort ahead of this lane's sample.
module tms_rank_lane
  import tms_pkg::*;
#(
  parameter int LANES = 5,
  parameter int LANE  = 0
) (
  input  sample_t   samples [LANES],
  input  count_t    count,
  output lane_res_t res
);

  count_t rank;

  // ties go to the lower field index
  always_comb begin
    rank = '0;
    for (int j = 0; j < LANES; j++) begin
      if (j != LANE && COUNT_W'(j) < count) begin
        if (samples[j] < samples[LANE] ||
            (samples[j] == samples[LANE] && j < LANE)) begin
          rank = rank + count_t'(1);
        end
      end
    end
  end

  assign res.used  = COUNT_W'(LANE) < count;
  assign res.rank  = rank;
  assign res.value = samples[LANE];

endmodule

### sv/tms_merge.sv
// Merge stage: picks the lane whose sample sits at the wanted rank.
module tms_merge
  import tms_pkg::*;
#(
  parameter int LANES = 5
) (
  input  lane_res_t lanes [LANES],
  input  count_t    want,
  output sample_t   median
);

  // exactly one used lane matches, so an OR of the gated values is enough
  always_comb begin
    median = '0;
    for (int i = 0; i < LANES; i++) begin
      if (lanes[i].used && lanes[i].rank == want) begin
        median = median | lanes[i].value;
      end
    end
  end

endmodule

### sv/temporal_median_select.sv
// Top level of the temporal median select block.
//
//   channel | direction | handshake              | payload
//   --------+-----------+------------------------+-------------------------------------
//   in_     | slave     | in_tvalid / in_tready  | in_tdata: sample_0 .. sample_4
//   out_    | master    | out_tvalid / out_tready| out_tdata: median_value
//   cfg_    | slave     | cfg_valid / cfg_ready  | cfg_data: frames_in_use
//
// One word per cycle when the output is not stalled; lane stage register, then output register.
// Lane count is min(MAX_FRAMES, 5); each lane combinationally ranks one sample against the rest.
// Reset (rst_n, synchronous) empties the pipe and sets frames_in_use to its maximum.
// A stalled output holds its word; the lane stage keeps accepting until it too is full.
module temporal_median_select
  import tms_pkg::*;
#(
  parameter int MAX_FRAMES = 5
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [79:0] in_tdata,   // sample_0 [15:0] .. sample_4 [79:64]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [15:0] out_tdata,  // median_value [15:0]
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_data    // frames_in_use [2:0]
);

  localparam int LANES = (MAX_FRAMES < SAMPLE_FIELDS) ? MAX_FRAMES : SAMPLE_FIELDS;

  count_t    cnt_r;
  count_t    cnt_nxt;
  logic      a_valid_r;
  lane_res_t a_res_r [LANES];
  logic      out_valid_r;
  sample_t   out_data_r;

  sample_t   samples [LANES];
  lane_res_t lane_res [LANES];
  sample_t   median;
  logic      out_adv;
  logic      a_ready;

  // effective frame count, clamped at write time
  always_comb begin
    cnt_nxt = cfg_data;
    if (cnt_nxt < COUNT_W'(MIN_FRAMES)) cnt_nxt = COUNT_W'(MIN_FRAMES);
    if (cnt_nxt > COUNT_W'(LANES))      cnt_nxt = COUNT_W'(LANES);
  end

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= COUNT_W'(LANES);
    end else if (cfg_valid) begin
      cnt_r <= cnt_nxt;
    end
  end

  // unpack the samples that have a lane
  for (genvar g = 0; g < LANES; g++) begin : g_lane
    assign samples[g] = in_tdata[g*SAMPLE_W +: SAMPLE_W];

    tms_rank_lane #(
      .LANES (LANES),
      .LANE  (g)
    ) u_lane (
      .samples (samples),
      .count   (cnt_r),
      .res     (lane_res[g])
    );
  end

  // pipe control
  assign out_adv   = !out_valid_r || out_tready;
  assign a_ready   = !a_valid_r || out_adv;
  assign in_tready = a_ready;

  // lane stage
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_valid_r <= 1'b0;
    end else if (a_ready) begin
      a_valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (a_ready && in_tvalid) begin
      a_res_r <= lane_res;
    end
  end

  tms_merge #(
    .LANES (LANES)
  ) u_merge (
    .lanes  (a_res_r),
    .want   (cnt_r >> 1),
    .median (median)
  );

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_adv) begin
      out_valid_r <= a_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (out_adv && a_valid_r) begin
      out_data_r <= median;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

endmodule

### sv/tms_checker.sv
// Port-level checks for the temporal median select block, bound to the top level.
module tms_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_tvalid,
  input logic        in_tready,
  input logic [79:0] in_tdata,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [15:0] out_tdata
);

  logic all_eq;
  assign all_eq = in_tdata[15:0] == in_tdata[31:16] && in_tdata[15:0] == in_tdata[47:32] &&
                  in_tdata[15:0] == in_tdata[63:48] && in_tdata[15:0] == in_tdata[79:64];

  // stalled output word holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("output word changed while stalled");

  // reset empties the pipe
  a_rst_empty: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("output valid after reset");

  // input only backs up when the output is full and stalled
  a_no_bubble: assert property (@(posedge clk) disable iff (!rst_n)
    !in_tready |-> out_tvalid && !out_tready)
    else $error("input stalled without output backpressure");

  // an accepted word reaches the output once the sink is ready
  a_flow: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready) ##1 out_tready |=> out_tvalid)
    else $error("accepted word did not reach the output");

  // all samples equal: median is that sample
  a_equal: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready && all_eq) ##1 out_tready |=> out_tdata == $past(in_tdata[15:0], 2))
    else $error("median of equal samples is wrong");

endmodule

bind temporal_median_select tms_checker u_tms_checker (.*);

### dv/median_board_pkg.sv
// Scoreboard for the temporal median select block: median prediction and result checks.
package median_board_pkg;
  import tms_pkg::*;

  localparam count_t FRAMES_AT_RESET = count_t'(5);

  class median_board;
    sample_t median_q[$];
    count_t  frames_reg;
    int      max_frames;
    int      mismatches;
    int      results_seen;

    function new(int max_frames_p);
      max_frames   = max_frames_p;
      frames_reg   = FRAMES_AT_RESET;
      mismatches   = 0;
      results_seen = 0;
    endfunction

    // sample at sorted rank n/2 among the frames in use, ties go by field order
    function sample_t median_of(logic [SAMPLE_FIELDS*SAMPLE_W-1:0] word);
      sample_t s [SAMPLE_FIELDS];
      sample_t pick;
      int      n;
      int      rank;
      n = frames_reg;
      if (n < MIN_FRAMES) n = MIN_FRAMES;
      if (n > max_frames) n = max_frames;
      if (n > SAMPLE_FIELDS) n = SAMPLE_FIELDS;
      for (int k = 0; k < SAMPLE_FIELDS; k++) s[k] = word[k*SAMPLE_W +: SAMPLE_W];
      pick = '0;
      for (int i = 0; i < n; i++) begin
        rank = 0;
        for (int j = 0; j < n; j++) begin
          if (s[j] < s[i] || (s[j] == s[i] && j < i)) rank++;
        end
        if (rank == n / 2) pick = s[i];
      end
      return pick;
    endfunction

    function void note_samples(logic [SAMPLE_FIELDS*SAMPLE_W-1:0] word);
      median_q.push_back(median_of(word));
    endfunction

    function int pending();
      return median_q.size();
    endfunction

    task report(string msg);
      $display("mismatch: %s", msg);
      mismatches++;
    endtask

    task check_median(sample_t got);
      sample_t want;
      results_seen++;
      if (median_q.size() == 0) begin
        report($sformatf("median %h with no word outstanding", got));
      end else begin
        want = median_q.pop_front();
        if (got !== want)
          report($sformatf("result %0d: median %h, predicted %h", results_seen, got, want));
      end
    endtask
  endclass

endpackage

### dv/tb_top.sv
// Testbench top for temporal_median_select: random and directed sample words, checked medians.
module tb_top;
  import tms_pkg::*;
  import median_board_pkg::*;

  localparam int MAX_FRAMES       = 5;
  localparam int WORD_W           = SAMPLE_FIELDS * SAMPLE_W;
  localparam int RANDOM_PER_PHASE = 62;
  localparam int QUIET_LIMIT      = 2000;
  localparam int HOLD_CYCLES      = 60;
  localparam int HOLD_AFTER       = 150;
  localparam int IDLE_PCT         = 32;
  localparam int DRAIN_CYCLES     = 8;
  localparam int STEADY_PHASE     = 3;

  typedef enum int {FULL_RANGE, FEW_VALUES, EXTREMES, CLUSTER} word_kind_e;

  logic              clk = 1'b0;
  logic              rst_n;
  logic              in_tvalid;
  logic              in_tready;
  logic [WORD_W-1:0] in_tdata;   // sample_0 [15:0] .. sample_4 [79:64]
  logic              out_tvalid;
  logic              out_tready;
  logic [15:0]       out_tdata;  // median_value [15:0]
  logic              cfg_valid;
  logic              cfg_ready;
  logic [2:0]        cfg_data;   // frames_in_use [2:0]

  median_board medians = new(MAX_FRAMES);
  bit          steady;
  bit          hold_done;
  int          quiet;

  logic [WORD_W-1:0] directed_words [17] = '{
    80'h0000_0000_0000_0000_0000,
    {5{16'hFFFF}},
    80'h0005_0004_0003_0002_0001,
    80'h0001_0002_0003_0004_0005,
    80'h0000_0000_0000_0000_FFFF,
    80'h0000_0000_0000_FFFF_0000,
    80'h0000_0000_FFFF_0000_0000,
    80'h0000_FFFF_0000_0000_0000,
    80'hFFFF_0000_0000_0000_0000,
    80'hFFFF_FFFF_FFFF_FFFF_0000,
    80'h0000_FFFF_FFFF_FFFF_FFFF,
    80'h0009_0003_0003_0007_0007,
    80'h0009_0002_0005_0005_0005,
    80'h0001_0001_8000_8000_8000,
    80'h5555_AAAA_5555_AAAA_5555,
    80'hAAAA_5555_AAAA_5555_AAAA,
    80'hFFFF_FFFF_0001_0002_0003
  };

  // every register value, extremes and out-of-range counts included
  count_t phase_frames [8] = '{3'd3, 3'd0, 3'd7, 3'd4, 3'd1, 3'd6, 3'd2, 3'd5};

  always #4 clk = ~clk;

  temporal_median_select #(.MAX_FRAMES(MAX_FRAMES)) uut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_data   (cfg_data)
  );

  // random sample word; some kinds force ties and extreme values
  function automatic logic [WORD_W-1:0] random_word();
    word_kind_e        kind;
    sample_t           base;
    sample_t           picks [3];
    logic [WORD_W-1:0] w;
    kind = word_kind_e'($urandom_range(0, 3));
    base = sample_t'($urandom_range(0, 65535));
    for (int i = 0; i < 3; i++) picks[i] = sample_t'($urandom_range(0, 65535));
    for (int k = 0; k < SAMPLE_FIELDS; k++) begin
      case (kind)
        FULL_RANGE: w[k*SAMPLE_W +: SAMPLE_W] = sample_t'($urandom_range(0, 65535));
        FEW_VALUES: w[k*SAMPLE_W +: SAMPLE_W] = picks[$urandom_range(0, 2)];
        EXTREMES: begin
          case ($urandom_range(0, 3))
            0:       w[k*SAMPLE_W +: SAMPLE_W] = 16'h0000;
            1:       w[k*SAMPLE_W +: SAMPLE_W] = 16'h0001;
            2:       w[k*SAMPLE_W +: SAMPLE_W] = 16'hFFFE;
            default: w[k*SAMPLE_W +: SAMPLE_W] = 16'hFFFF;
          endcase
        end
        default: w[k*SAMPLE_W +: SAMPLE_W] = base + sample_t'($urandom_range(0, 3));
      endcase
    end
    return w;
  endfunction

  // offer one word, with random gaps ahead of it outside the steady phase; leaves tvalid high on return
  task automatic push_samples(logic [WORD_W-1:0] word);
    while (!steady && $urandom_range(0, 99) < IDLE_PCT) begin
      in_tvalid = 1'b0;
      @(negedge clk);
    end
    in_tvalid = 1'b1;
    in_tdata  = word;
    do @(posedge clk); while (!in_tready);
    medians.note_samples(word);
    @(negedge clk);
  endtask

  // frame count write, only once the pipe has drained
  task automatic write_frames(count_t count);
    in_tvalid = 1'b0;
    while (medians.pending() != 0) @(negedge clk);
    repeat (3) @(negedge clk);
    cfg_valid = 1'b1;
    cfg_data  = count;
    do @(posedge clk); while (!cfg_ready);
    medians.frames_reg = count;
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  // result side ready, with one long hold-off to back the block up
  initial begin
    out_tready = 1'b0;
    forever begin
      @(negedge clk);
      if (!hold_done && medians.results_seen >= HOLD_AFTER) begin
        out_tready = 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
        hold_done = 1'b1;
      end
      out_tready = steady || ($urandom_range(0, 99) >= IDLE_PCT);
    end
  end

  // result check
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) medians.check_median(out_tdata);
  end

  // watchdog on cycles with no handshake anywhere
  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready) || (cfg_valid && cfg_ready))
        quiet = 0;
      else
        quiet++;
      if (quiet >= QUIET_LIMIT) begin
        $display("CHECK FAILED");
        $finish;
      end
    end
  end

  initial begin
    rst_n     = 1'b0;
    in_tvalid = 1'b0;
    in_tdata  = '0;
    cfg_valid = 1'b0;
    cfg_data  = '0;
    steady    = 1'b0;
    hold_done = 1'b0;
    quiet     = 0;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // directed words at the reset frame count
    foreach (directed_words[i]) push_samples(directed_words[i]);

    // random words under each frame count
    foreach (phase_frames[p]) begin
      write_frames(phase_frames[p]);
      steady = (p == STEADY_PHASE);
      repeat (RANDOM_PER_PHASE) push_samples(random_word());
      steady = 1'b0;
    end
    in_tvalid = 1'b0;

    while (medians.pending() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
    if (medians.pending() != 0)
      medians.report($sformatf("%0d medians never arrived", medians.pending()));

    if (medians.mismatches == 0)
      $display("CHECK OK");
    else
      $display("CHECK FAILED");
    $finish;
  end

endmodule

### files.f
sv/tms_pkg.sv
sv/tms_rank_lane.sv
sv/tms_merge.sv
sv/temporal_median_select.sv
sv/tms_checker.sv
dv/median_board_pkg.sv
dv/tb_top.sv
